/* hdl/prtw_pkg.sv */
// ----------------------------------------------------------------------------
// prtw_pkg: shared types and codes for the priority / timed wait scheduler
// holds the input and result word structs and the operation codes
// ----------------------------------------------------------------------------
package prtw_pkg;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  thread_id;
    logic [1:0]  priority_req;
    logic [15:0] sleep_time;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [7:0] next_thread;
    logic [1:0] next_priority;
    logic       dropped;
  } out_word_t;

  // one waiter as it sits in a cell of the sorted wait chain
  typedef struct packed {
    logic [31:0] wake;
    logic [7:0]  id;
    logic [1:0]  prio;
  } waiter_t;

  // command broadcast to every wait cell
  typedef struct packed {
    logic    ins;    // insert new waiter
    logic    pop;    // remove head, shift toward head
    waiter_t item;
  } wait_cmd_t;

endpackage

/* hdl/priority_ready_and_timed_wait_scheduler_top.sv */
// ----------------------------------------------------------------------------
// priority_ready_and_timed_wait_scheduler_top: thread scheduler
// strict priority ready queues plus a wait chain sorted by wake time
// ----------------------------------------------------------------------------
//  channel  direction  word        handshake
//  in       input      in_word_t   in_valid / in_stall
//  out      output     out_word_t  out_valid / out_stall
//
// add, tick and the unused code pass from accept through the exec and done
// states to the result; get-next passes through exec, the promotion loop
// (one pop of the wait chain head per cycle into the ready queues), pick
// and done, repeating promotion and pick once when time jumps to the earliest wake.
// one word at a time; the next word is taken once the result register
// is empty. reset clears the queues, counts and time.
// ----------------------------------------------------------------------------
module priority_ready_and_timed_wait_scheduler_top #(
  parameter int NUM_PRIO    = 4,
  parameter int READY_DEPTH = 16,
  parameter int WAIT_DEPTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  prtw_pkg::in_word_t in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output prtw_pkg::out_word_t out_word
);

  localparam int PW = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;  // add or tick; get moves on to promote
  localparam logic [2:0] S_PROM  = 3'd2;  // promote due waiters
  localparam logic [2:0] S_PICK  = 3'd3;  // dequeue or jump time
  localparam logic [2:0] S_DONE  = 3'd4;  // result goes to the output register

  logic [2:0]         state;
  prtw_pkg::in_word_t cur;
  logic [31:0]        now_ms;
  logic               pass;   // second try after time jump
  logic               drop;
  logic               found;
  logic [7:0]         nid;
  logic [PW-1:0]      nprio;

  // saturate the requested level
  logic [PW-1:0] req_prio;
  always_comb begin
    if (32'(cur.priority_req) >= 32'(NUM_PRIO)) begin
      req_prio = PW'(NUM_PRIO - 1);
    end else begin
      req_prio = PW'(cur.priority_req);
    end
  end

  // wait chain
  prtw_pkg::wait_cmd_t wcmd;
  logic                w_hv;
  prtw_pkg::waiter_t   w_head;
  logic                w_full;
  logic                due;

  assign due = w_hv && (w_head.wake <= now_ms);

  // ready queues
  logic          f_push;
  logic [PW-1:0] f_pprio;
  logic [7:0]    f_pid;
  logic          f_full;
  logic          f_pop;
  logic          f_any;
  logic [PW-1:0] f_best;
  logic [7:0]    f_bid;

  logic add_wait;
  assign add_wait = (cur.operation == prtw_pkg::OP_ADD) && (cur.sleep_time != '0);

  always_comb begin
    wcmd      = '0;
    wcmd.item = '{wake: now_ms + 32'(cur.sleep_time), id: cur.thread_id,
                  prio: 2'(req_prio)};
    f_push  = 1'b0;
    f_pprio = req_prio;
    f_pid   = cur.thread_id;
    f_pop   = 1'b0;
    unique case (state)
      S_EXEC: begin
        if (add_wait) begin
          wcmd.ins = !w_full;
        end else if (cur.operation == prtw_pkg::OP_ADD) begin
          f_push = 1'b1;
        end
      end
      S_PROM: begin
        if (due) begin
          wcmd.pop = 1'b1;
          f_push   = 1'b1;
          f_pprio  = PW'(w_head.prio);
          f_pid    = w_head.id;
        end
      end
      S_PICK: f_pop = 1'b1;
      default: ;
    endcase
  end

  prtw_wait_chain #(.WAIT_DEPTH(WAIT_DEPTH)) u_wait (
    .clk(clk), .rst(rst), .cmd(wcmd),
    .head_valid(w_hv), .head(w_head), .full(w_full)
  );

  // the last promotion cycle pushes nothing, so the registered head read
  // is settled when the pick state uses it
  prtw_ready_fifos #(.NUM_PRIO(NUM_PRIO), .READY_DEPTH(READY_DEPTH)) u_ready (
    .clk(clk), .rst(rst),
    .push(f_push), .push_prio(f_pprio), .push_id(f_pid), .push_full(f_full),
    .pop(f_pop), .any(f_any), .best(f_best), .best_id(f_bid)
  );

  // accept only when idle and the result slot is free
  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cur <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now_ms    <= '0;
      out_valid <= 1'b0;
      pass      <= 1'b0;
      drop      <= 1'b0;
      found     <= 1'b0;
      nid       <= '0;
      nprio     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            state <= S_EXEC;
            pass  <= 1'b0;
            drop  <= 1'b0;
            found <= 1'b0;
            nid   <= '0;
            nprio <= '0;
          end
        end
        S_EXEC: begin
          if (cur.operation == prtw_pkg::OP_GET) begin
            state <= S_PROM;
          end else begin
            if (cur.operation == prtw_pkg::OP_ADD) begin
              drop <= add_wait ? w_full : f_full;
            end
            if (cur.operation == prtw_pkg::OP_TICK) begin
              now_ms <= now_ms + 32'd1;
            end
            state <= S_DONE;
          end
        end
        S_PROM: begin
          if (due) begin
            if (f_full) begin
              drop <= 1'b1;
            end
          end else begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (f_any) begin
            found <= 1'b1;
            nid   <= f_bid;
            nprio <= f_best;
            state <= S_DONE;
          end else if (w_hv && !pass) begin
            now_ms <= w_head.wake;
            pass   <= 1'b1;
            state  <= S_PROM;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_word = '{found: found, next_thread: nid,
                      next_priority: 2'(nprio), dropped: drop};

endmodule

/* hdl/prtw_wait_cell.sv */
// ----------------------------------------------------------------------------
// prtw_wait_cell: one slot of the sorted wait chain
// holds one waiter; on insert it keeps, takes the new item or takes its left
// neighbor, on pop it takes its right neighbor
// ----------------------------------------------------------------------------
module prtw_wait_cell (
  input  logic                clk,
  input  logic                rst,
  input  prtw_pkg::wait_cmd_t cmd,
  input  logic                left_valid,
  input  logic                left_goes,   // left neighbor is pushed past
  input  prtw_pkg::waiter_t   left_item,
  input  logic                right_valid,
  input  prtw_pkg::waiter_t   right_item,
  output logic                valid,
  output logic                goes,        // this slot's item shifts right
  output prtw_pkg::waiter_t   item
);

  logic beyond;  // new item belongs at or before this slot

  // equal wake times keep arrival order: new item goes after them
  assign beyond = !valid || (item.wake > cmd.item.wake);
  assign goes   = cmd.ins && valid && beyond;

  // only the first empty slot or a shifted slot becomes valid on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end else if (cmd.ins && beyond && left_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      item <= right_item;
    end else if (cmd.ins && beyond) begin
      if (left_goes) begin
        item <= left_item;
      end else if (left_valid) begin
        item <= cmd.item;
      end
    end
  end

endmodule

/* hdl/prtw_wait_chain.sv */
// ----------------------------------------------------------------------------
// prtw_wait_chain: row of wait cells, head at index 0
// ----------------------------------------------------------------------------
module prtw_wait_chain #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  prtw_pkg::wait_cmd_t cmd,
  output logic                head_valid,
  output prtw_pkg::waiter_t   head,
  output logic                full
);

  logic              v [WAIT_DEPTH+1];
  logic              g [WAIT_DEPTH+1];
  prtw_pkg::waiter_t it [WAIT_DEPTH+1];

  assign v[WAIT_DEPTH]  = 1'b0;
  assign g[WAIT_DEPTH]  = 1'b0;
  assign it[WAIT_DEPTH] = '0;

  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
    logic              lv;
    logic              lg;
    prtw_pkg::waiter_t li;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign li = '0;
    end else begin : g_rest
      assign lv = v[i-1];
      assign lg = g[i-1];
      assign li = it[i-1];
    end
    prtw_wait_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .left_valid(lv), .left_goes(lg), .left_item(li),
      .right_valid(v[i+1]), .right_item(it[i+1]),
      .valid(v[i]), .goes(g[i]), .item(it[i])
    );
  end

  assign head_valid = v[0];
  assign head       = it[0];
  assign full       = v[WAIT_DEPTH-1];

endmodule

/* hdl/prtw_ready_fifos.sv */
// ----------------------------------------------------------------------------
// prtw_ready_fifos: one circular ready queue per priority level
// single memory, one push and one pop port; pop picks lowest level
// best_id is a registered read of the current best head, so it is valid
// in the cycle after the queues last changed
// ----------------------------------------------------------------------------
module prtw_ready_fifos #(
  parameter int NUM_PRIO    = 4,
  parameter int READY_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [$clog2(NUM_PRIO)-1:0] push_prio,
  input  logic [7:0]                  push_id,
  output logic                        push_full,
  input  logic                        pop,
  output logic                        any,
  output logic [$clog2(NUM_PRIO)-1:0] best,
  output logic [7:0]                  best_id
);

  localparam int PW = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int AW = $clog2(READY_DEPTH);
  localparam int CW = $clog2(READY_DEPTH + 1);
  localparam int MW = $clog2(NUM_PRIO * READY_DEPTH);

  logic [7:0]    mem [NUM_PRIO*READY_DEPTH];
  logic [CW-1:0] count [NUM_PRIO];
  logic [AW-1:0] head  [NUM_PRIO];
  logic [AW-1:0] tail;
  logic [AW:0]   tsum;
  logic [AW-1:0] hnext;
  logic [MW-1:0] waddr;
  logic [MW-1:0] raddr;

  always_comb begin
    any  = 1'b0;
    best = '0;
    for (int p = NUM_PRIO - 1; p >= 0; p--) begin
      if (count[p] != '0) begin
        any  = 1'b1;
        best = p[PW-1:0];
      end
    end
  end

  assign push_full = (count[push_prio] == CW'(READY_DEPTH));
  assign tsum      = {1'b0, head[push_prio]} + count[push_prio][AW:0];
  assign tail      = (tsum >= (AW+1)'(READY_DEPTH)) ?
                     AW'(tsum - (AW+1)'(READY_DEPTH)) : tsum[AW-1:0];
  assign hnext     = (head[best] == AW'(READY_DEPTH - 1)) ? '0 : head[best] + 1'b1;
  assign waddr     = MW'(push_prio * READY_DEPTH) + MW'(tail);
  assign raddr     = MW'(best * READY_DEPTH) + MW'(head[best]);

  always_ff @(posedge clk) begin
    if (push && !push_full) begin
      mem[waddr] <= push_id;
    end
    best_id <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PRIO; p++) begin
        count[p] <= '0;
        head[p]  <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PRIO; p++) begin
        logic inc;
        logic dec;
        inc = push && !push_full && (push_prio == p[PW-1:0]);
        dec = pop && any && (best == p[PW-1:0]);
        if (dec) begin
          head[p] <= hnext;
        end
        if (inc && !dec) begin
          count[p] <= count[p] + 1'b1;
        end else if (dec && !inc) begin
          count[p] <= count[p] - 1'b1;
        end
      end
    end
  end

endmodule
